// ----- hdl/amfd_pkg.sv -----
// ----------------------------------------------------------------------------
// amfd_pkg: shared types and constants of the actor message frame decoder
// Header layout, status codes, queue entry and result word.
// ----------------------------------------------------------------------------
package amfd_pkg;

  localparam int HEADER_BYTES = 50;

  // byte offsets of the little-endian header fields
  localparam logic [5:0] OFS_VERSION = 6'd0;
  localparam logic [5:0] OFS_TYPE    = 6'd1;
  localparam logic [5:0] OFS_FLAGS   = 6'd2;
  localparam logic [5:0] OFS_SNODE   = 6'd6;
  localparam logic [5:0] OFS_SACTOR  = 6'd14;
  localparam logic [5:0] OFS_SGEN    = 6'd22;
  localparam logic [5:0] OFS_TNODE   = 6'd26;
  localparam logic [5:0] OFS_TACTOR  = 6'd34;
  localparam logic [5:0] OFS_TGEN    = 6'd42;
  localparam logic [5:0] OFS_LENGTH  = 6'd46;
  localparam logic [5:0] HDR_END     = 6'(HEADER_BYTES);

  localparam logic [7:0] ENVELOPE_VERSION   = 8'd1;
  localparam logic [7:0] TYPE_ACTOR_MESSAGE = 8'd3;
  localparam int         FEATURE_REMOTE_BIT = 0;

  localparam logic [32:0] SEEN_MAX = {33{1'b1}};

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_TRUNCATED       = 3'd1,
    ST_BAD_VERSION     = 3'd2,
    ST_BAD_TYPE        = 3'd3,
    ST_LEN_MISMATCH    = 3'd4,
    ST_FEATURE_MISSING = 3'd5
  } status_e;

  // header fields, first field in the lowest bits
  typedef struct packed {
    logic [31:0] declared_length;
    logic [31:0] target_generation;
    logic [63:0] target_actor;
    logic [63:0] target_node;
    logic [31:0] sender_generation;
    logic [63:0] sender_actor;
    logic [63:0] sender_node;
    logic [31:0] flag_word;
  } hdr_t;

  // one queued job: a payload byte, a frame status, or both
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_payload;
    logic       has_status;
    status_e    status;
    hdr_t       hdr;
  } q_entry_t;

  // result word as it leaves on tdata, zero fill in the top bits
  typedef struct packed {
    logic [4:0] pad;
    hdr_t       hdr;
    status_e    status;
    logic [7:0] payload_byte;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

// ----- hdl/amfd_front.sv -----
// ----------------------------------------------------------------------------
// amfd_front: byte intake and classification
// Tracks the header position, assembles header fields, counts payload bytes
// and pushes payload and status jobs into the queue.
// ----------------------------------------------------------------------------
module amfd_front import amfd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  logic     [7:0] data_byte_i,
  input  logic     frame_end_i,
  output logic     push_o,
  output q_entry_t entry_o
);

  logic [5:0]  pos_q, pos_d;
  logic [32:0] seen_q, seen_d;
  logic [7:0]  ver_q, ver_d;
  logic [7:0]  typ_q, typ_d;
  hdr_t        hdr_q, hdr_d;
  logic [5:0]  off;
  logic        in_header;
  status_e     status;

  always_comb begin
    pos_d     = pos_q;
    seen_d    = seen_q;
    ver_d     = ver_q;
    typ_d     = typ_q;
    hdr_d     = hdr_q;
    off       = '0;
    in_header = (pos_q < HDR_END);
    if (in_header) begin
      pos_d = pos_q + 6'd1;
      case (pos_q) inside
        OFS_VERSION: ver_d = data_byte_i;
        OFS_TYPE:    typ_d = data_byte_i;
        [OFS_FLAGS:OFS_SNODE - 6'd1]: begin
          off = pos_q - OFS_FLAGS;
          hdr_d.flag_word[{off[1:0], 3'b000} +: 8] = data_byte_i;
        end
        [OFS_SNODE:OFS_SACTOR - 6'd1]: begin
          off = pos_q - OFS_SNODE;
          hdr_d.sender_node[{off[2:0], 3'b000} +: 8] = data_byte_i;
        end
        [OFS_SACTOR:OFS_SGEN - 6'd1]: begin
          off = pos_q - OFS_SACTOR;
          hdr_d.sender_actor[{off[2:0], 3'b000} +: 8] = data_byte_i;
        end
        [OFS_SGEN:OFS_TNODE - 6'd1]: begin
          off = pos_q - OFS_SGEN;
          hdr_d.sender_generation[{off[1:0], 3'b000} +: 8] = data_byte_i;
        end
        [OFS_TNODE:OFS_TACTOR - 6'd1]: begin
          off = pos_q - OFS_TNODE;
          hdr_d.target_node[{off[2:0], 3'b000} +: 8] = data_byte_i;
        end
        [OFS_TACTOR:OFS_TGEN - 6'd1]: begin
          off = pos_q - OFS_TACTOR;
          hdr_d.target_actor[{off[2:0], 3'b000} +: 8] = data_byte_i;
        end
        [OFS_TGEN:OFS_LENGTH - 6'd1]: begin
          off = pos_q - OFS_TGEN;
          hdr_d.target_generation[{off[1:0], 3'b000} +: 8] = data_byte_i;
        end
        default: begin
          off = pos_q - OFS_LENGTH;
          hdr_d.declared_length[{off[1:0], 3'b000} +: 8] = data_byte_i;
        end
      endcase
    end else if (seen_q != SEEN_MAX) begin
      seen_d = seen_q + 33'd1;
    end
  end

  // status checks in priority order, on the state including this byte
  always_comb begin
    if (pos_d < OFS_SNODE) begin
      status = ST_TRUNCATED;
    end else if (ver_d != ENVELOPE_VERSION) begin
      status = ST_BAD_VERSION;
    end else if (typ_d != TYPE_ACTOR_MESSAGE) begin
      status = ST_BAD_TYPE;
    end else if (pos_d < HDR_END) begin
      status = ST_TRUNCATED;
    end else if (seen_d != {1'b0, hdr_d.declared_length}) begin
      status = ST_LEN_MISMATCH;
    end else if (!hdr_d.flag_word[FEATURE_REMOTE_BIT]) begin
      status = ST_FEATURE_MISSING;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    entry_o.data_byte   = data_byte_i;
    entry_o.has_payload = !in_header;
    entry_o.has_status  = frame_end_i;
    entry_o.status      = status;
    entry_o.hdr         = hdr_d;
    push_o              = accept_i && (!in_header || frame_end_i);
  end

  // clear everything after the frame's last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      seen_q <= '0;
      ver_q  <= '0;
      typ_q  <= '0;
      hdr_q  <= '0;
    end else if (accept_i) begin
      if (frame_end_i) begin
        pos_q  <= '0;
        seen_q <= '0;
        ver_q  <= '0;
        typ_q  <= '0;
        hdr_q  <= '0;
      end else begin
        pos_q  <= pos_d;
        seen_q <= seen_d;
        ver_q  <= ver_d;
        typ_q  <= typ_d;
        hdr_q  <= hdr_d;
      end
    end
  end

endmodule

// ----- hdl/amfd_queue.sv -----
// ----------------------------------------------------------------------------
// amfd_queue: job queue between front and back
// Small circular buffer of decoded jobs; lets intake and output stall apart.
// ----------------------------------------------------------------------------
module amfd_queue import amfd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  input  logic     pop_i,
  output logic     full_o,
  output logic     head_valid_o,
  output q_entry_t head_o
);

  q_entry_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  count_q, count_d;

  assign full_o       = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

// ----- hdl/amfd_back.sv -----
// ----------------------------------------------------------------------------
// amfd_back: result generation
// Turns queued jobs into result words in an output register; a job with
// both a payload byte and a status yields the payload first.
// ----------------------------------------------------------------------------
module amfd_back import amfd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  q_entry_t            head_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [RESULT_W-1:0] m_axis_tdata,
  output logic                m_axis_tlast
);

  logic    phase_q, phase_d;
  logic    out_valid_q, out_valid_d;
  logic    out_last_q, out_last_d;
  result_t out_q, out_d;
  logic    load;

  assign load = head_valid_i && (!out_valid_q || m_axis_tready);

  always_comb begin
    phase_d     = phase_q;
    out_last_d  = out_last_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    if (load) begin
      out_valid_d = 1'b1;
      if (head_i.has_payload && !phase_q) begin
        out_d              = '0;
        out_d.payload_byte = head_i.data_byte;
        out_last_d         = 1'b0;
        // hold the job when its status still has to follow
        phase_d            = head_i.has_status;
        pop_o              = !head_i.has_status;
      end else begin
        out_d        = '0;
        out_d.status = head_i.status;
        out_d.hdr    = head_i.hdr;
        out_last_d   = 1'b1;
        phase_d      = 1'b0;
        pop_o        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = out_last_q;

  a_phase_needs_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q && head_valid_i) |-> (head_i.has_payload && head_i.has_status))
    else $error("second phase on a job without payload and status");

  a_status_clears_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && phase_q) |=> (!phase_q && m_axis_tlast))
    else $error("status not emitted after payload half");

endmodule

// ----- hdl/actor_message_frame_decoder_core.sv -----
// ----------------------------------------------------------------------------
// actor_message_frame_decoder_core: actor message frame decoder, top level
// Front intake, job queue and result back end.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle on s_axis, tlast on the frame's
// last byte. The 50-byte little-endian header is decoded in the intake
// stage; every byte after it leaves as a payload result (tlast low), and the
// last byte of a frame adds a status result (tlast high) carrying the header
// fields. Results leave from an output register, at most one per cycle, and
// only after their jobs are stored in the queue. A last byte that is also payload
// causes two results; a four-entry job queue absorbs these, so the intake
// runs at one byte per cycle until the output side stalls or the queue fills.
// There is no configuration and no clearing pass after reset.
module actor_message_frame_decoder_core import amfd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] data_byte
  input  logic                s_axis_tlast,  // frame_end
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] payload_byte, [10:8] status, [42:11] flag_word,
  // [106:43] sender_node, [170:107] sender_actor, [202:171] sender_generation,
  // [266:203] target_node, [330:267] target_actor, [362:331] target_generation,
  // [394:363] declared_length, [399:395] zero
  output logic [RESULT_W-1:0] m_axis_tdata,
  output logic                m_axis_tlast   // kind
);

  logic     accept;
  logic     push;
  logic     pop;
  logic     full;
  logic     head_valid;
  q_entry_t entry;
  q_entry_t head;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  amfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (s_axis_tdata),
    .frame_end_i (s_axis_tlast),
    .push_o      (push),
    .entry_o     (entry)
  );

  amfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  amfd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stream-level check of actor_message_frame_decoder_core
// Feeds directed and random frames byte by byte, predicts the payload and
// status results in a scoreboard, and compares every result field by field.
// ----------------------------------------------------------------------------
module testbench;
  import amfd_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int TAIL_CYCLES  = 20;
  localparam int TARGET_BYTES = 1450;
  localparam int QUIET_BYTES  = 1250;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic    kind;
    result_t word;
  } outcome_t;

  class frame_scoreboard;
    outcome_t    outcome_q[$];
    int          mismatches;
    int          hdr_count;
    logic [32:0] payload_count;
    logic [7:0]  version;
    logic [7:0]  msg_type;
    hdr_t        hdr;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      hdr_count     = 0;
      payload_count = '0;
      version       = '0;
      msg_type      = '0;
      hdr           = '0;
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    function void store_header_byte(int pos, logic [7:0] b);
      if (pos == OFS_VERSION) version = b;
      else if (pos == OFS_TYPE) msg_type = b;
      else if (pos < OFS_SNODE) hdr.flag_word[(pos - OFS_FLAGS) * 8 +: 8] = b;
      else if (pos < OFS_SACTOR) hdr.sender_node[(pos - OFS_SNODE) * 8 +: 8] = b;
      else if (pos < OFS_SGEN) hdr.sender_actor[(pos - OFS_SACTOR) * 8 +: 8] = b;
      else if (pos < OFS_TNODE) hdr.sender_generation[(pos - OFS_SGEN) * 8 +: 8] = b;
      else if (pos < OFS_TACTOR) hdr.target_node[(pos - OFS_TNODE) * 8 +: 8] = b;
      else if (pos < OFS_TGEN) hdr.target_actor[(pos - OFS_TACTOR) * 8 +: 8] = b;
      else if (pos < OFS_LENGTH) hdr.target_generation[(pos - OFS_TGEN) * 8 +: 8] = b;
      else hdr.declared_length[(pos - OFS_LENGTH) * 8 +: 8] = b;
    endfunction

    function status_e frame_status();
      if (hdr_count < OFS_SNODE) return ST_TRUNCATED;
      if (version != ENVELOPE_VERSION) return ST_BAD_VERSION;
      if (msg_type != TYPE_ACTOR_MESSAGE) return ST_BAD_TYPE;
      if (hdr_count < HEADER_BYTES) return ST_TRUNCATED;
      if (payload_count != {1'b0, hdr.declared_length}) return ST_LEN_MISMATCH;
      if (!hdr.flag_word[FEATURE_REMOTE_BIT]) return ST_FEATURE_MISSING;
      return ST_OK;
    endfunction

    // Called on every accepted input transfer.
    function void note_byte(logic [7:0] b, logic last);
      outcome_t item;
      if (hdr_count < HEADER_BYTES) begin
        store_header_byte(hdr_count, b);
        hdr_count++;
      end else begin
        if (payload_count != SEEN_MAX) payload_count++;
        item = '0;
        item.word.payload_byte = b;
        item.word.status = ST_OK;
        outcome_q.insert(outcome_q.size(), item);
      end
      if (last) begin
        item = '0;
        item.kind = 1'b1;
        item.word.status = frame_status();
        item.word.hdr = hdr;
        outcome_q.insert(outcome_q.size(), item);
        clear();
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch %s: expected %h, got %h", name, want, got);
      end
    endfunction

    // Called on every accepted output transfer.
    function void check_result(logic [RESULT_W-1:0] data, logic last);
      outcome_t want;
      result_t  got;
      got = data;
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: tlast %b tdata %h", last, data);
        return;
      end
      want = outcome_q.pop_front();
      compare_field("kind", want.kind, last);
      compare_field("payload_byte", want.word.payload_byte, got.payload_byte);
      compare_field("status", want.word.status, got.status);
      compare_field("flag_word", want.word.hdr.flag_word, got.hdr.flag_word);
      compare_field("sender_node", want.word.hdr.sender_node, got.hdr.sender_node);
      compare_field("sender_actor", want.word.hdr.sender_actor, got.hdr.sender_actor);
      compare_field("sender_generation", want.word.hdr.sender_generation,
                    got.hdr.sender_generation);
      compare_field("target_node", want.word.hdr.target_node, got.hdr.target_node);
      compare_field("target_actor", want.word.hdr.target_actor, got.hdr.target_actor);
      compare_field("target_generation", want.word.hdr.target_generation,
                    got.hdr.target_generation);
      compare_field("declared_length", want.word.hdr.declared_length,
                    got.hdr.declared_length);
      compare_field("pad", '0, got.pad);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // [7:0] data_byte
  logic                s_axis_tlast;   // frame_end
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [RESULT_W-1:0] m_axis_tdata;   // result_t, payload_byte in the lowest bits
  logic                m_axis_tlast;   // kind

  frame_scoreboard sb = new();
  logic [7:0]      frame_bytes[$];
  int              bytes_taken;
  int              cycles;
  bit              idle_on;
  bit              hold_req;

  actor_message_frame_decoder_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  // Result sink: random stall bursts, plus one long hold on request.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  function automatic void append_byte(logic [7:0] b);
    frame_bytes = {frame_bytes, b};
  endfunction

  function automatic void push_le(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) append_byte(v[i * 8 +: 8]);
  endfunction

  // id_mode: 0 random ids, 1 all zeros, 2 all ones; cut > 0 shortens the frame
  function automatic void build_frame(logic [7:0] ver, logic [7:0] msg,
                                      logic [31:0] flags, logic [31:0] len,
                                      int payload_n, int id_mode, int cut);
    logic [63:0] ids[4];
    logic [31:0] gens[2];
    for (int i = 0; i < 4; i++)
      ids[i] = (id_mode == 0) ? {$urandom, $urandom} : {64{id_mode == 2}};
    for (int i = 0; i < 2; i++)
      gens[i] = (id_mode == 0) ? $urandom : {32{id_mode == 2}};
    frame_bytes.delete();
    push_le(64'(ver), 1);
    push_le(64'(msg), 1);
    push_le(64'(flags), 4);
    push_le(ids[0], 8);
    push_le(ids[1], 8);
    push_le(64'(gens[0]), 4);
    push_le(ids[2], 8);
    push_le(ids[3], 8);
    push_le(64'(gens[1]), 4);
    push_le(64'(len), 4);
    repeat (payload_n) append_byte(8'($urandom_range(0, 255)));
    if (cut > 0)
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
  endfunction

  // Enter and leave at a falling edge; valid stays high after the transfer.
  task automatic send_byte(logic [7:0] d, logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(d, last);
    bytes_taken++;
    @(negedge clk_i);
  endtask

  task automatic transmit_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  initial begin
    int frame_no;
    int sel;
    int n;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    rst_ni        = 1'b0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    bytes_taken   = 0;
    cycles        = 0;
    frame_no      = 0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // single byte, and a header cut before the type checks
    build_frame(ENVELOPE_VERSION, TYPE_ACTOR_MESSAGE, 32'h1, 0, 0, 0, 1);
    transmit_frame();
    build_frame(ENVELOPE_VERSION, TYPE_ACTOR_MESSAGE, 32'h1, 0, 0, 0, 5);
    transmit_frame();
    // bad version, bad type
    build_frame(8'h00, TYPE_ACTOR_MESSAGE, 32'h1, 0, 0, 0, 0);
    transmit_frame();
    build_frame(8'hFF, TYPE_ACTOR_MESSAGE, 32'hFFFF_FFFF, 2, 2, 2, 0);
    transmit_frame();
    build_frame(ENVELOPE_VERSION, 8'hFF, 32'h1, 0, 0, 1, 0);
    transmit_frame();
    // good version and type but header incomplete
    build_frame(ENVELOPE_VERSION, TYPE_ACTOR_MESSAGE, 32'h1, 0, 0, 0, 6);
    transmit_frame();
    build_frame(ENVELOPE_VERSION, TYPE_ACTOR_MESSAGE, 32'h1, 0, 0, 0, 49);
    transmit_frame();
    // header only, then last byte in payload
    build_frame(ENVELOPE_VERSION, TYPE_ACTOR_MESSAGE, 32'h1, 0, 0, 1, 0);
    transmit_frame();
    build_frame(ENVELOPE_VERSION, TYPE_ACTOR_MESSAGE, 32'h1, 4, 4, 0, 0);
    transmit_frame();
    // length mismatch both ways, feature bit missing, all ones
    build_frame(ENVELOPE_VERSION, TYPE_ACTOR_MESSAGE, 32'h1, 5, 3, 0, 0);
    transmit_frame();
    build_frame(ENVELOPE_VERSION, TYPE_ACTOR_MESSAGE, 32'h1, 32'hFFFF_FFFF, 2, 0, 0);
    transmit_frame();
    build_frame(ENVELOPE_VERSION, TYPE_ACTOR_MESSAGE, 32'h1, 1, 2, 0, 0);
    transmit_frame();
    build_frame(ENVELOPE_VERSION, TYPE_ACTOR_MESSAGE, 32'hFFFF_FFFE, 3, 3, 2, 0);
    transmit_frame();
    build_frame(ENVELOPE_VERSION, TYPE_ACTOR_MESSAGE, 32'hFFFF_FFFF, 1, 1, 2, 0);
    transmit_frame();
    wait_drained();

    while (bytes_taken < TARGET_BYTES) begin
      if (bytes_taken > QUIET_BYTES) idle_on = 1'b0;
      frame_no++;
      sel = $urandom_range(0, 19);
      n = $urandom_range(0, 16);
      if (frame_no == 6) begin
        // long sink hold while a long payload keeps coming
        hold_req = 1'b1;
        build_frame(ENVELOPE_VERSION, TYPE_ACTOR_MESSAGE, $urandom | 32'h1, 40, 40, 0, 0);
      end else if (sel < 13) begin
        build_frame(ENVELOPE_VERSION, TYPE_ACTOR_MESSAGE,
                    ($urandom_range(0, 7) == 0) ? ($urandom & 32'hFFFF_FFFE)
                                                : ($urandom | 32'h1),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : n,
                    n, 0, 0);
      end else if (sel < 15) begin
        build_frame(ENVELOPE_VERSION, TYPE_ACTOR_MESSAGE, $urandom, n, n, 0,
                    $urandom_range(1, HEADER_BYTES - 1));
      end else if (sel < 17) begin
        build_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), $urandom,
                    n, n, 0, 0);
      end else begin
        frame_bytes.delete();
        repeat ($urandom_range(1, 70)) append_byte(8'($urandom_range(0, 255)));
      end
      transmit_frame();
      if (frame_no == 6 || frame_no == 15) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
